// ===== src/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared constants, codes and beat types of the text console cursor control.
// ----------------------------------------------------------------------------
package tcc_pkg;

  // Field widths of the channels
  localparam int CHAR_W     = 8;
  localparam int CELL_COL_W = 7;
  localparam int CELL_ROW_W = 6;
  localparam int COLOR_W    = 32;

  // Grid geometry defaults
  localparam int DEF_COLS     = 128;
  localparam int DEF_ROWS     = 48;
  localparam int DEF_TAB_STOP = 4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_COLOR = 1'b1;
  localparam logic [COLOR_W-1:0]   COLOR_RESET      = 32'h00FF_FFFF;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BACKSPACE  = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB        = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE      = 8'd32;
  localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'd95;

  // Renderer commands
  localparam logic CMD_DRAW   = 1'b0;
  localparam logic CMD_SCROLL = 1'b1;

  // Most beats one character can cause
  localparam int MAX_BEATS = 3;
  localparam int CNT_W     = 2;

  typedef struct packed {
    logic                  command;
    logic [CHAR_W-1:0]     glyph_code;
    logic [CELL_COL_W-1:0] cell_col;
    logic [CELL_ROW_W-1:0] cell_row;
    logic [COLOR_W-1:0]    draw_color;
    logic                  last_of_run;
  } cmd_beat_t;

  typedef struct packed {
    cmd_beat_t [MAX_BEATS-1:0] beat;
    logic [CNT_W-1:0]          count;
  } run_t;

endpackage

// ===== src/tcc_char_if.sv =====
// ----------------------------------------------------------------------------
// tcc_char_if
// Character input channel: one byte per beat.
// ----------------------------------------------------------------------------
interface tcc_char_if;
  logic                        valid;
  logic                        ready;
  logic [tcc_pkg::CHAR_W-1:0]  char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

// ===== src/tcc_cmd_if.sv =====
// ----------------------------------------------------------------------------
// tcc_cmd_if
// Renderer command channel: one draw or scroll command per beat.
// ----------------------------------------------------------------------------
interface tcc_cmd_if;
  logic                             valid;
  logic                             ready;
  logic                             command;
  logic [tcc_pkg::CHAR_W-1:0]       glyph_code;
  logic [tcc_pkg::CELL_COL_W-1:0]   cell_col;
  logic [tcc_pkg::CELL_ROW_W-1:0]   cell_row;
  logic [tcc_pkg::COLOR_W-1:0]      draw_color;
  logic                             last_of_run;

  modport source (output valid, output command, output glyph_code, output cell_col,
                  output cell_row, output draw_color, output last_of_run, input ready);
  modport sink   (input valid, input command, input glyph_code, input cell_col,
                  input cell_row, input draw_color, input last_of_run, output ready);
endinterface

// ===== src/text_console_cursor_control.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_control
// Keep a text cursor and turn each byte into draw and scroll commands.
// ----------------------------------------------------------------------------
//
//  channel   dir  width            beat carries
//  --------  ---  ---------------  ------------------------------------------
//  chars     in   8                one character byte
//  cmds      out  1+8+7+6+32+1     one draw or scroll command, last_of_run
//  cfg_*     in   1 index, 32 data text_color / cursor_color, write only
//
//  A byte is decoded against the cursor in the cycle it is accepted; the
//  cursor updates at once and the run of one to three commands is stored.
//  The run buffer drains one beat per cycle into the output register while
//  that register is empty or being taken by cmds.
//  A new byte is taken in the cycle the last beat of the previous run
//  moves to the output register. Stalls on cmds hold the output register
//  and back up into chars. Synchronous reset: cursor at (0, 0), colors
//  0xFFFFFF, no run pending.
//
module text_console_cursor_control #(
  parameter int COLS     = tcc_pkg::DEF_COLS,
  parameter int ROWS     = tcc_pkg::DEF_ROWS,
  parameter int TAB_STOP = tcc_pkg::DEF_TAB_STOP
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcc_pkg::COLOR_W-1:0]   cfg_data,
  tcc_char_if.sink                      chars,
  tcc_cmd_if.source                     cmds
);
  import tcc_pkg::*;

  localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PH_W  = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;

  // cursor state; phase tracks col modulo the tab stop
  logic [COL_W-1:0]   cursor_col, col_next;
  logic [ROW_W-1:0]   cursor_row, row_next;
  logic [PH_W-1:0]    phase, phase_next;
  logic [COLOR_W-1:0] text_color;
  logic [COLOR_W-1:0] cursor_color;

  run_t run;
  logic room;
  logic accept;

  assign chars.ready = room;
  assign accept      = chars.valid && room;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color   <= COLOR_RESET;
      cursor_color <= COLOR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEXT_COLOR:   text_color   <= cfg_data;
        CFG_CURSOR_COLOR: cursor_color <= cfg_data;
        default: ;
      endcase
    end
  end

  // advance the cursor on every accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
      phase      <= '0;
    end else if (accept) begin
      cursor_col <= col_next;
      cursor_row <= row_next;
      phase      <= phase_next;
    end
  end

  tcc_step #(
    .COLS     (COLS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_step (
    .char_code    (chars.char_code),
    .col          (cursor_col),
    .row          (cursor_row),
    .phase        (phase),
    .text_color   (text_color),
    .cursor_color (cursor_color),
    .col_next     (col_next),
    .row_next     (row_next),
    .phase_next   (phase_next),
    .run          (run)
  );

  tcc_run u_run (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .run_in (run),
    .room   (room),
    .cmds   (cmds)
  );

endmodule

// ===== src/tcc_step.sv =====
// ----------------------------------------------------------------------------
// tcc_step
// Decode one byte against the cursor state: next cursor and the beat run.
// ----------------------------------------------------------------------------
module tcc_step #(
  parameter int COLS     = tcc_pkg::DEF_COLS,
  parameter int ROWS     = tcc_pkg::DEF_ROWS,
  parameter int TAB_STOP = tcc_pkg::DEF_TAB_STOP,
  localparam int COL_W   = (COLS > 1) ? $clog2(COLS) : 1,
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int PH_W    = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1
) (
  input  logic [tcc_pkg::CHAR_W-1:0]  char_code,
  input  logic [COL_W-1:0]            col,
  input  logic [ROW_W-1:0]            row,
  input  logic [PH_W-1:0]             phase,
  input  logic [tcc_pkg::COLOR_W-1:0] text_color,
  input  logic [tcc_pkg::COLOR_W-1:0] cursor_color,
  output logic [COL_W-1:0]            col_next,
  output logic [ROW_W-1:0]            row_next,
  output logic [PH_W-1:0]             phase_next,
  output tcc_pkg::run_t               run
);
  import tcc_pkg::*;

  localparam int SUM_W = COL_W + 6;
  localparam logic [COL_W-1:0] LAST_COL   = COL_W'(COLS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW   = ROW_W'(ROWS - 1);
  localparam logic [PH_W-1:0]  LAST_PHASE = PH_W'(TAB_STOP - 1);
  localparam logic [PH_W-1:0]  CLAMP_PH   = PH_W'((COLS - 1) % TAB_STOP);

  function automatic cmd_beat_t draw_beat(input logic [CHAR_W-1:0] glyph,
                                          input logic [COL_W-1:0] c,
                                          input logic [ROW_W-1:0] r,
                                          input logic [COLOR_W-1:0] color);
    cmd_beat_t b;
    b.command     = CMD_DRAW;
    b.glyph_code  = glyph;
    b.cell_col    = CELL_COL_W'(c);
    b.cell_row    = CELL_ROW_W'(r);
    b.draw_color  = color;
    b.last_of_run = 1'b0;
    return b;
  endfunction

  function automatic logic [PH_W-1:0] phase_inc(input logic [PH_W-1:0] p);
    return (p == LAST_PHASE) ? '0 : p + 1'b1;
  endfunction

  cmd_beat_t scroll_beat;
  assign scroll_beat = '{command: CMD_SCROLL, default: '0};

  always_comb begin
    logic [1:0]         n;
    logic [SUM_W-1:0]   stop;
    logic [COL_W-1:0]   c0;
    logic [ROW_W-1:0]   r0;
    cmd_beat_t          cursor_b;

    n          = '0;
    run        = '0;
    col_next   = col;
    row_next   = row;
    phase_next = phase;
    c0         = col;
    r0         = row;
    stop       = SUM_W'(col) + SUM_W'(TAB_STOP) - SUM_W'(phase);

    case (char_code)
      CH_NEWLINE: begin
        // erase, go to column 0 of the next row, scroll at the bottom
        run.beat[n] = draw_beat(CH_SPACE, col, row, text_color);
        n = n + 1'b1;
        col_next   = '0;
        phase_next = '0;
        if (row == LAST_ROW) begin
          run.beat[n] = scroll_beat;
          n = n + 1'b1;
        end else begin
          row_next = row + 1'b1;
        end
      end
      CH_BACKSPACE: begin
        run.beat[n] = draw_beat(CH_SPACE, col, row, text_color);
        n = n + 1'b1;
        if (col != '0) begin
          col_next   = col - 1'b1;
          phase_next = (phase == '0) ? LAST_PHASE : phase - 1'b1;
        end
      end
      CH_TAB: begin
        if (stop > SUM_W'(COLS - 1)) begin
          col_next   = LAST_COL;
          phase_next = CLAMP_PH;
        end else begin
          col_next   = COL_W'(stop);
          phase_next = '0;
        end
      end
      default: begin
        if (col == LAST_COL) begin
          c0 = '0;
          if (row == LAST_ROW) begin
            run.beat[n] = scroll_beat;
            n = n + 1'b1;
          end else begin
            r0 = row + 1'b1;
          end
          run.beat[n] = draw_beat(char_code, c0, r0, text_color);
          n = n + 1'b1;
          phase_next = phase_inc('0);
        end else begin
          run.beat[n] = draw_beat(char_code, c0, r0, text_color);
          n = n + 1'b1;
          phase_next = phase_inc(phase);
        end
        col_next = c0 + 1'b1;
        row_next = r0;
      end
    endcase

    cursor_b             = draw_beat(CH_UNDERSCORE, col_next, row_next, cursor_color);
    cursor_b.last_of_run = 1'b1;
    run.beat[n]          = cursor_b;
    run.count            = n + 1'b1;
  end

endmodule

// ===== src/tcc_run.sv =====
// ----------------------------------------------------------------------------
// tcc_run
// Run buffer and output register: drain a stored beat run one beat a cycle while cmds takes them.
// ----------------------------------------------------------------------------
module tcc_run (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  tcc_pkg::run_t     run_in,
  output logic              room,
  tcc_cmd_if.source         cmds
);
  import tcc_pkg::*;

  cmd_beat_t [MAX_BEATS-1:0] beats;
  logic [CNT_W-1:0]          left;
  logic [CNT_W-1:0]          idx;
  logic                      out_valid;
  cmd_beat_t                 out_beat;
  logic                      move;

  // advance a beat into the output register when it is empty or being taken
  assign move = (left != '0) && (!out_valid || cmds.ready);
  assign room = (left == '0) || ((left == CNT_W'(1)) && move);

  always_ff @(posedge clk) begin
    if (rst) begin
      left      <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        left <= run_in.count;
        idx  <= '0;
      end else if (move) begin
        left <= left - 1'b1;
        idx  <= idx + 1'b1;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (cmds.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beats <= run_in.beat;
    end
    if (move) begin
      out_beat <= beats[idx];
    end
  end

  assign cmds.valid       = out_valid;
  assign cmds.command     = out_beat.command;
  assign cmds.glyph_code  = out_beat.glyph_code;
  assign cmds.cell_col    = out_beat.cell_col;
  assign cmds.cell_row    = out_beat.cell_row;
  assign cmds.draw_color  = out_beat.draw_color;
  assign cmds.last_of_run = out_beat.last_of_run;

endmodule
